### hdl/ddodo_pkg.sv
// ----------------------------------------------------------------------------
// ddodo_pkg
// Types and constants for the differential drive odometry block: register
// indexes, fixed-point scale factors, cordic arctangent table, sequencer states.
// ----------------------------------------------------------------------------
package ddodo_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_WHEEL_RADIUS = 3'd0;
	localparam logic [2:0] REG_WHEEL_BASE   = 3'd1;
	localparam logic [2:0] REG_TICK_PERIOD  = 3'd2;
	localparam logic [2:0] REG_INIT_X       = 3'd3;
	localparam logic [2:0] REG_INIT_Y       = 3'd4;
	localparam logic [2:0] REG_INIT_HEADING = 3'd5;

	localparam logic [15:0] RADIUS_RST = 16'd6554;
	localparam logic [19:0] BASE_RST   = 20'd32768;
	localparam logic [15:0] PERIOD_RST = 16'd655;

	// round(pi/960 * 2^40), rpm*radius*period to travel in 2^-32 m
	localparam logic [31:0] PATH_SCALE = 32'd3598143388;
	// inverse cordic gain in q30
	localparam logic signed [31:0] GAIN_INV = 32'sd652032874;

	localparam logic signed [47:0] POS_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] POS_MIN = 48'sh8000_0000_0000;

	// heading bounds for the half-turn fold
	localparam logic [23:0] QUARTER_TURN = 24'h400000;
	localparam logic [23:0] HALF_TURN    = 24'h800000;
	localparam logic [23:0] THREE_QUARTER = 24'hC00000;

	localparam int CORDIC_MAX = 24;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_CORD = 6'b000010,
		ST_MULA = 6'b000100,
		ST_MULB = 6'b001000,
		ST_MULC = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

	// atan(2^-i) in 2^-32 turn units
	function automatic logic [31:0] atan_lut(input logic [4:0] idx);
		logic [31:0] v;
		case (idx)
			5'd0:  v = 32'h20000000;
			5'd1:  v = 32'h12E4051E;
			5'd2:  v = 32'h09FB385B;
			5'd3:  v = 32'h051111D4;
			5'd4:  v = 32'h028B0D43;
			5'd5:  v = 32'h0145D7E1;
			5'd6:  v = 32'h00A2F61E;
			5'd7:  v = 32'h00517C55;
			5'd8:  v = 32'h0028BE53;
			5'd9:  v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2FA;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

### hdl/differential_drive_odometry.sv
// ----------------------------------------------------------------------------
// differential_drive_odometry
// Euler dead reckoning for a two-wheel robot: bit-serial multipliers and a
// restoring divider, an iterative cordic, saturating 48-bit position state.
// ----------------------------------------------------------------------------
// sequence: an accepted input runs the cordic and the period-radius product
// (ST_CORD), then the shift-add multipliers (17 + 32 + 32 bit-serial steps in
// ST_MULA, ST_MULB, ST_MULC) with the divider; ST_FIN registers the result once
// the output can take it, and the next input can be taken in the cycle after.
// reset: pose clears to zero, geometry registers load their defaults, no result
// pending.
module differential_drive_odometry #(
	parameter int CORDIC_STEPS = 18
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [2:0]          cfg_index,
	input  logic [47:0]         cfg_data,
	input  logic                rpm_valid,
	output logic                rpm_stall,
	input  logic signed [15:0]  left_speed,
	input  logic signed [15:0]  right_speed,
	output logic                pose_valid,
	input  logic                pose_stall,
	output logic signed [47:0]  pos_x,
	output logic signed [47:0]  pos_y,
	output logic [23:0]         heading
);

	localparam int NCORD = (CORDIC_STEPS < ddodo_pkg::CORDIC_MAX) ?
		CORDIC_STEPS : ddodo_pkg::CORDIC_MAX;
	localparam int LEN_CORD = (NCORD > 16) ? NCORD : 16;

	ddodo_pkg::state_t state_q;
	logic [4:0]  cnt_q;
	logic        out_vld_q;

	logic [15:0] radius_q;
	logic [19:0] base_q;
	logic [15:0] period_q;
	logic signed [47:0] x_q;
	logic signed [47:0] y_q;
	logic [23:0] h_q;

	logic        sum_neg_q, diff_neg_q, flip_q;
	logic [31:0] rt_q;
	logic signed [31:0] cx_q, cy_q, cz_q;
	logic [48:0] pa_q, pd_q;
	logic [48:0] ts_q;
	logic [40:0] s_q;
	logic [31:0] mx_q, my_q;
	logic        sgx_q, sgy_q;
	logic [40:0] ax_q, ay_q;

	logic        div_busy_q;
	logic [5:0]  div_cnt_q;
	logic [24:0] rem_q, dvs_q;
	logic [51:0] num_q;
	logic [23:0] q_q;

	logic        in_xfer, fin_go;
	logic [16:0] sum_in, diff_in, sum_abs, diff_abs;
	logic        h_flip;
	logic [23:0] h_fold;
	logic [19:0] base_nz;
	logic [23:0] den;
	logic [16:0] rt_sum;
	logic signed [31:0] xs, ys;
	logic [31:0] atan_v;
	logic [32:0] pa_sum, pd_sum;
	logic [49:0] ts_sum;
	logic [41:0] ax_sum, ay_sum;
	logic [25:0] trial;
	logic        cneg_x, cneg_y;
	logic [40:0] rx, ry;
	logic signed [48:0] dx, dy, xsum, ysum;
	logic signed [47:0] x_new, y_new;
	logic [23:0] h_new;

	assign in_xfer    = rpm_valid && !rpm_stall;
	assign rpm_stall  = (state_q != ddodo_pkg::ST_IDLE);
	assign pose_valid = out_vld_q;
	assign pos_x      = x_q;
	assign pos_y      = y_q;
	assign heading    = h_q;
	assign fin_go     = (state_q == ddodo_pkg::ST_FIN) && !div_busy_q &&
		(!out_vld_q || !pose_stall);

	always_comb begin
		sum_in   = {left_speed[15], left_speed} + {right_speed[15], right_speed};
		diff_in  = {right_speed[15], right_speed} - {left_speed[15], left_speed};
		sum_abs  = sum_in[16] ? (17'd0 - sum_in) : sum_in;
		diff_abs = diff_in[16] ? (17'd0 - diff_in) : diff_in;

		// between a quarter and three quarters of a turn: fold by a half turn, negate results later
		h_flip = (h_q > ddodo_pkg::QUARTER_TURN && h_q < ddodo_pkg::HALF_TURN) ||
			(h_q >= ddodo_pkg::HALF_TURN && h_q < ddodo_pkg::THREE_QUARTER);
		h_fold = h_flip ? (h_q ^ ddodo_pkg::HALF_TURN) : h_q;

		base_nz = (base_q == 20'd0) ? 20'd1 : base_q;
		den     = {base_nz, 4'b0000} - {4'b0000, base_nz};

		rt_sum = {1'b0, rt_q[31:16]} + (rt_q[0] ? {1'b0, radius_q} : 17'd0);

		xs     = cx_q >>> cnt_q;
		ys     = cy_q >>> cnt_q;
		atan_v = ddodo_pkg::atan_lut(cnt_q);

		pa_sum = {1'b0, pa_q[48:17]} + (pa_q[0] ? {1'b0, rt_q} : 33'd0);
		pd_sum = {1'b0, pd_q[48:17]} + (pd_q[0] ? {1'b0, rt_q} : 33'd0);

		ts_sum = {1'b0, ts_q} + (ddodo_pkg::PATH_SCALE[cnt_q] ? {1'b0, pa_q} : 50'd0);

		ax_sum = {1'b0, ax_q} + (mx_q[0] ? {1'b0, s_q} : 42'd0);
		ay_sum = {1'b0, ay_q} + (my_q[0] ? {1'b0, s_q} : 42'd0);

		trial = {rem_q, num_q[51]} - {1'b0, dvs_q};

		cneg_x = flip_q ? (cx_q > 32'sd0) : (cx_q < 32'sd0);
		cneg_y = flip_q ? (cy_q > 32'sd0) : (cy_q < 32'sd0);

		rx = ax_q + 41'h2000;
		ry = ay_q + 41'h2000;
		dx = sgx_q ? (49'sd0 - $signed({22'd0, rx[40:14]})) : $signed({22'd0, rx[40:14]});
		dy = sgy_q ? (49'sd0 - $signed({22'd0, ry[40:14]})) : $signed({22'd0, ry[40:14]});
		xsum = {x_q[47], x_q} + dx;
		ysum = {y_q[47], y_q} + dy;
		if (xsum[48] != xsum[47]) begin
			x_new = xsum[48] ? ddodo_pkg::POS_MIN : ddodo_pkg::POS_MAX;
		end else begin
			x_new = xsum[47:0];
		end
		if (ysum[48] != ysum[47]) begin
			y_new = ysum[48] ? ddodo_pkg::POS_MIN : ddodo_pkg::POS_MAX;
		end else begin
			y_new = ysum[47:0];
		end
		h_new = diff_neg_q ? (h_q - q_q) : (h_q + q_q);
	end

	// sequencer, configuration and pose state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ddodo_pkg::ST_IDLE;
			cnt_q      <= '0;
			out_vld_q  <= 1'b0;
			div_busy_q <= 1'b0;
			div_cnt_q  <= '0;
			radius_q   <= ddodo_pkg::RADIUS_RST;
			base_q     <= ddodo_pkg::BASE_RST;
			period_q   <= ddodo_pkg::PERIOD_RST;
			x_q        <= '0;
			y_q        <= '0;
			h_q        <= '0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					ddodo_pkg::REG_WHEEL_RADIUS: radius_q <= cfg_data[15:0];
					ddodo_pkg::REG_WHEEL_BASE:   base_q   <= cfg_data[19:0];
					ddodo_pkg::REG_TICK_PERIOD:  period_q <= cfg_data[15:0];
					ddodo_pkg::REG_INIT_X:       x_q      <= cfg_data;
					ddodo_pkg::REG_INIT_Y:       y_q      <= cfg_data;
					ddodo_pkg::REG_INIT_HEADING: h_q      <= cfg_data[23:0];
					default: ;
				endcase
			end

			if (fin_go) begin
				out_vld_q <= 1'b1;
			end else if (!pose_stall) begin
				out_vld_q <= 1'b0;
			end

			if (div_busy_q) begin
				div_cnt_q <= div_cnt_q + 6'd1;
				if (div_cnt_q == 6'd51) begin
					div_busy_q <= 1'b0;
				end
			end

			case (state_q)
				ddodo_pkg::ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ddodo_pkg::ST_CORD;
						cnt_q   <= '0;
					end
				end
				ddodo_pkg::ST_CORD: begin
					if (cnt_q == 5'(LEN_CORD - 1)) begin
						state_q <= ddodo_pkg::ST_MULA;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ddodo_pkg::ST_MULA: begin
					if (cnt_q == 5'd16) begin
						state_q    <= ddodo_pkg::ST_MULB;
						cnt_q      <= '0;
						div_busy_q <= 1'b1;
						div_cnt_q  <= '0;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ddodo_pkg::ST_MULB: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						state_q <= ddodo_pkg::ST_MULC;
					end
				end
				ddodo_pkg::ST_MULC: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						state_q <= ddodo_pkg::ST_FIN;
					end
				end
				ddodo_pkg::ST_FIN: begin
					if (fin_go) begin
						state_q <= ddodo_pkg::ST_IDLE;
						x_q     <= x_new;
						y_q     <= y_new;
						h_q     <= h_new;
					end
				end
				default: state_q <= ddodo_pkg::ST_IDLE;
			endcase
		end
	end

	// datapath: serial products, cordic iterations, divider
	always_ff @(posedge clk) begin
		case (state_q)
			ddodo_pkg::ST_IDLE: begin
				if (in_xfer) begin
					sum_neg_q  <= sum_in[16];
					diff_neg_q <= diff_in[16];
					pa_q       <= {32'd0, sum_abs};
					pd_q       <= {32'd0, diff_abs};
					rt_q       <= {16'd0, period_q};
					flip_q     <= h_flip;
					cx_q       <= ddodo_pkg::GAIN_INV;
					cy_q       <= '0;
					cz_q       <= {h_fold, 8'd0};
				end
			end
			ddodo_pkg::ST_CORD: begin
				if (cnt_q < 5'd16) begin
					rt_q <= {rt_sum, rt_q[15:1]};
				end
				if (cnt_q < 5'(NCORD)) begin
					if (!cz_q[31]) begin
						cx_q <= cx_q - ys;
						cy_q <= cy_q + xs;
						cz_q <= cz_q - $signed(atan_v);
					end else begin
						cx_q <= cx_q + ys;
						cy_q <= cy_q - xs;
						cz_q <= cz_q + $signed(atan_v);
					end
				end
			end
			ddodo_pkg::ST_MULA: begin
				pa_q <= {pa_sum, pa_q[16:1]};
				pd_q <= {pd_sum, pd_q[16:1]};
				if (cnt_q == 5'd16) begin
					ts_q <= '0;
					// 2*num + den with num = 4*|diff|*rt, divided by 2*den
					num_q <= {1'b0, pd_sum[31:0], pd_q[16:1], 3'b000} + {28'd0, den};
					dvs_q <= {den, 1'b0};
					rem_q <= '0;
				end
			end
			ddodo_pkg::ST_MULB: begin
				ts_q <= ts_sum[49:1];
				if (cnt_q == 5'd31) begin
					s_q   <= ts_sum[49:9] + {40'd0, ts_sum[8]};
					mx_q  <= cx_q[31] ? (32'd0 - cx_q) : cx_q;
					my_q  <= cy_q[31] ? (32'd0 - cy_q) : cy_q;
					sgx_q <= sum_neg_q ^ cneg_x;
					sgy_q <= sum_neg_q ^ cneg_y;
					ax_q  <= '0;
					ay_q  <= '0;
				end
			end
			ddodo_pkg::ST_MULC: begin
				ax_q <= ax_sum[41:1];
				ay_q <= ay_sum[41:1];
				mx_q <= {1'b0, mx_q[31:1]};
				my_q <= {1'b0, my_q[31:1]};
			end
			default: ;
		endcase

		if (div_busy_q) begin
			num_q <= {num_q[50:0], 1'b0};
			if (!trial[25]) begin
				rem_q <= trial[24:0];
				q_q   <= {q_q[22:0], 1'b1};
			end else begin
				rem_q <= {rem_q[23:0], num_q[51]};
				q_q   <= {q_q[22:0], 1'b0};
			end
		end
	end

endmodule
